[rtl/accel_log_heatmap_colorizer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the heat-map colorizer
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ACCEL_LOG_HEATMAP_COLORIZER_CORE_MACROS_SVH
`define ACCEL_LOG_HEATMAP_COLORIZER_CORE_MACROS_SVH

// same-cycle implication
`define ALHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colorizer assertion failed");

// next-cycle implication
`define ALHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colorizer assertion failed");

`endif

[rtl/alhc_pkg.sv]
// ----------------------------------------------------------------------------
// alhc_pkg
// Widths, constants and tables of the heat-map colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package alhc_pkg;

    localparam int COLOR_STOPS = 7;
    localparam int STOP_MUL    = COLOR_STOPS - 1;
    localparam int LOG_N       = 256;
    localparam int LOG_B       = $clog2(LOG_N);
    localparam int ROM_AW      = LOG_B + 1;

    localparam int SQ_W     = 34;
    localparam int RAD_W    = SQ_W + 16;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQ_PER   = 5;
    localparam int SQ_STG   = ROOT_W / SQ_PER;

    localparam int PL_W  = ROOT_W + 16;
    localparam int X_W   = 58;
    localparam int E_W   = 5;
    localparam int EN    = X_W - 32;
    localparam int G_W   = 22;
    localparam int P_W   = G_W + 16;
    localparam int N_W   = P_W - 16;
    localparam int D_W   = N_W + 32;
    localparam int S_W   = 21;
    localparam int J_W   = 5;

    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [15:0] OFFSET_Q16 = 16'd9830;
    localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;

    localparam logic REG_INV = 1'b0;
    localparam logic [31:0] INV_RESET = 32'd65536;

    // stop colors, bit 2 red, bit 1 green, bit 0 blue
    typedef logic [2:0] t_stops [16];
    localparam t_stops STOP_RGB = '{
        3'b000, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b111, 3'b111,
        3'b111, 3'b111, 3'b111, 3'b111, 3'b111, 3'b111, 3'b111, 3'b111
    };

    typedef logic [16:0] t_rom [LOG_N + 1];

    function automatic t_rom build_log_rom();
        t_rom        v_rom;
        logic [63:0] v_y;
        logic [16:0] v_r;
        for (int k = 0; k <= LOG_N; k++) begin
            if (k == LOG_N) begin
                v_rom[k] = ONE_Q16;
            end else begin
                v_y = (64'd1 << 30) + ((64'(k) << 30) / LOG_N);
                v_r = '0;
                for (int n = 0; n < 16; n++) begin
                    v_y = (v_y * v_y) >> 30;
                    v_r = {v_r[15:0], 1'b0};
                    if (v_y >= (64'd2 << 30)) begin
                        v_y = v_y >> 1;
                        v_r[0] = 1'b1;
                    end
                end
                v_rom[k] = v_r;
            end
        end
        return v_rom;
    endfunction

    localparam t_rom LOG_ROM = build_log_rom();

endpackage

`default_nettype wire

[rtl/alhc_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// alhc_sqrt_pipe
// Pipelined digit-by-digit integer square root of (sq << 16).
// ----------------------------------------------------------------------------
`default_nettype none

module alhc_sqrt_pipe (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [alhc_pkg::SQ_W-1:0]     i_sq,
    input  wire logic                          i_last,
    output logic                               o_vld,
    output logic [alhc_pkg::ROOT_W-1:0]        o_root,
    output logic                               o_last
);

    logic [alhc_pkg::REM_W-1:0]  r_rem  [alhc_pkg::SQ_STG];
    logic [alhc_pkg::ROOT_W-1:0] r_root [alhc_pkg::SQ_STG];
    logic [alhc_pkg::SQ_W-1:0]   r_sq   [alhc_pkg::SQ_STG];
    logic                        r_last [alhc_pkg::SQ_STG];
    logic                        r_vld  [alhc_pkg::SQ_STG];

    for (genvar g = 0; g < alhc_pkg::SQ_STG; g++) begin : g_stg
        logic [alhc_pkg::REM_W-1:0]  w_rem_in;
        logic [alhc_pkg::ROOT_W-1:0] w_root_in;
        logic [alhc_pkg::SQ_W-1:0]   w_sq_in;
        logic                        w_last_in;
        logic                        w_vld_in;
        logic [alhc_pkg::REM_W-1:0]  n_rem;
        logic [alhc_pkg::ROOT_W-1:0] n_root;

        if (g == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_sq_in   = i_sq;
            assign w_last_in = i_last;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
            assign w_sq_in   = r_sq[g-1];
            assign w_last_in = r_last[g-1];
            assign w_vld_in  = r_vld[g-1];
        end

        always_comb begin
            logic [alhc_pkg::RAD_W-1:0] v_rad;
            logic [alhc_pkg::REM_W-1:0] v_trial;
            int                         k;
            v_rad  = {w_sq_in, 16'b0};
            n_rem  = w_rem_in;
            n_root = w_root_in;
            for (int s = 0; s < alhc_pkg::SQ_PER; s++) begin
                k       = alhc_pkg::ROOT_W - 1 - g * alhc_pkg::SQ_PER - s;
                n_rem   = {n_rem[alhc_pkg::REM_W-3:0], v_rad[2*k+1 -: 2]};
                v_trial = alhc_pkg::REM_W'({n_root, 2'b01});
                if (n_rem >= v_trial) begin
                    n_rem  = n_rem - v_trial;
                    n_root = {n_root[alhc_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[alhc_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_sq[g]   <= w_sq_in;
                r_last[g] <= w_last_in;
            end
        end
    end

    assign o_vld  = r_vld[alhc_pkg::SQ_STG-1];
    assign o_root = r_root[alhc_pkg::SQ_STG-1];
    assign o_last = r_last[alhc_pkg::SQ_STG-1];

endmodule

`default_nettype wire

[rtl/accel_log_heatmap_colorizer_core.sv]
// ----------------------------------------------------------------------------
// accel_log_heatmap_colorizer_core
// Colors a particle by log of its acceleration magnitude over a heat-map ramp.
//
// Channel   Direction  Handshake                Payload
// input     in         i_valid / o_ready        old/new velocity x,y, last
// output    out        o_valid / i_ready        red, green, blue, last
// config    in         APB, pready always high  inv_timestep at address 0
//
// One request per cycle while the output is not stalled; 19 register stages.
// Depth is set by the 5-stage square root and the split 25x32 multiply.
// All stages advance together; a stalled output holds the whole pipeline.
// Synchronous active-low reset clears valids and sets inv_timestep to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_log_heatmap_colorizer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_old_vel_x,
    input  wire logic signed [15:0] i_old_vel_y,
    input  wire logic signed [15:0] i_new_vel_x,
    input  wire logic signed [15:0] i_new_vel_y,
    input  wire logic               i_last_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic                    o_last_out,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [2:0]         i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output logic [31:0]             o_prdata,
    output logic                    o_pready
);

    logic        w_adv;
    logic [31:0] r_inv;

    logic signed [16:0] r_dx, r_dy;
    logic               r_v1, r_l1;
    logic [33:0]        r_sqx, r_sqy;
    logic               r_v2, r_l2;
    logic [alhc_pkg::SQ_W-1:0] r_sq;
    logic               r_v3, r_l3;

    logic                        w_sv, w_sl;
    logic [alhc_pkg::ROOT_W-1:0] w_root;

    logic [alhc_pkg::PL_W-1:0] r_pl, r_ph;
    logic                      r_vm1, r_lm1;
    logic [alhc_pkg::X_W-1:0]  r_x, r_x3;
    logic                      r_vm2, r_lm2;
    logic [alhc_pkg::E_W-1:0]  r_e3, r_e4, r_e5, r_e6;
    logic                      r_vm3, r_lm3;
    logic [31:0]               r_m;
    logic                      r_vm4, r_lm4;
    logic [16:0]               r_lo, r_hi, r_lo6;
    logic [15:0]               r_r;
    logic                      r_vm5, r_lm5;
    logic [32:0]               r_prod;
    logic                      r_vm6, r_lm6;
    logic [alhc_pkg::G_W-1:0]  r_g;
    logic                      r_vm7, r_lm7;
    logic [alhc_pkg::P_W-1:0]  r_p;
    logic                      r_vm8, r_lm8;
    logic [alhc_pkg::D_W-1:0]  r_d;
    logic                      r_vm9, r_lm9;
    logic [16:0]               r_f;
    logic                      r_vm10, r_lm10;
    logic                      r_ov;
    logic [7:0]                r_red, r_green, r_blue;
    logic                      r_lo_out;

    logic signed [33:0]        w_sqx, w_sqy;
    logic [alhc_pkg::E_W-1:0]  n_e;
    logic [alhc_pkg::X_W-1:0]  w_sh;
    logic [alhc_pkg::LOG_B-1:0] w_idx;
    logic [16:0]               w_diff;
    logic [19:0]               w_fs;
    logic [alhc_pkg::S_W-1:0]  w_s;
    logic [alhc_pkg::J_W-1:0]  w_j;
    logic [15:0]               w_q;
    logic [7:0]                n_ch [3];

    assign w_adv    = !r_ov || i_ready;
    assign o_ready  = w_adv;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == alhc_pkg::REG_INV) ? r_inv : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= alhc_pkg::INV_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == alhc_pkg::REG_INV)) begin
            r_inv <= i_pwdata;
        end
    end

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;

    alhc_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_v3),
        .i_sq    (r_sq),
        .i_last  (r_l3),
        .o_vld   (w_sv),
        .o_root  (w_root),
        .o_last  (w_sl)
    );

    always_comb begin
        n_e = '0;
        for (int b = 0; b < alhc_pkg::EN; b++) begin
            if (r_x[32 + b]) begin
                n_e = alhc_pkg::E_W'(b);
            end
        end
    end

    assign w_sh   = r_x3 >> r_e3;
    assign w_idx  = r_m[31 -: alhc_pkg::LOG_B];
    assign w_diff = r_hi - r_lo;
    assign w_fs   = 20'(r_d[alhc_pkg::D_W-1:35]) + 20'(alhc_pkg::OFFSET_Q16);
    assign w_s    = alhc_pkg::S_W'(r_f) * alhc_pkg::S_W'(alhc_pkg::STOP_MUL);
    assign w_j    = w_s[alhc_pkg::S_W-1:16];
    assign w_q    = w_s[15:0];

    always_comb begin
        logic [2:0]  v_c0, v_c1;
        logic [24:0] v_up, v_dn;
        v_up = 25'(w_q) * 25'd255 + 25'd32768;
        v_dn = 25'd16744448 - 25'(w_q) * 25'd255;
        v_c0 = alhc_pkg::STOP_RGB[w_j[3:0]];
        v_c1 = alhc_pkg::STOP_RGB[w_j[3:0] + 4'd1];
        if (w_j >= alhc_pkg::J_W'(alhc_pkg::STOP_MUL)) begin
            v_c0 = alhc_pkg::STOP_RGB[alhc_pkg::STOP_MUL];
            v_c1 = v_c0;
        end
        for (int ch = 0; ch < 3; ch++) begin
            if (v_c0[2-ch] == v_c1[2-ch]) begin
                n_ch[ch] = v_c0[2-ch] ? 8'd255 : 8'd0;
            end else if (v_c1[2-ch]) begin
                n_ch[ch] = v_up[23:16];
            end else begin
                n_ch[ch] = v_dn[23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_vm1 <= 1'b0; r_vm2 <= 1'b0; r_vm3 <= 1'b0; r_vm4 <= 1'b0;
            r_vm5 <= 1'b0; r_vm6 <= 1'b0; r_vm7 <= 1'b0; r_vm8 <= 1'b0;
            r_vm9 <= 1'b0; r_vm10 <= 1'b0; r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
            r_vm1 <= w_sv; r_vm2 <= r_vm1; r_vm3 <= r_vm2; r_vm4 <= r_vm3;
            r_vm5 <= r_vm4; r_vm6 <= r_vm5; r_vm7 <= r_vm6; r_vm8 <= r_vm7;
            r_vm9 <= r_vm8; r_vm10 <= r_vm9; r_ov <= r_vm10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx  <= {i_new_vel_x[15], i_new_vel_x} - {i_old_vel_x[15], i_old_vel_x};
            r_dy  <= {i_new_vel_y[15], i_new_vel_y} - {i_old_vel_y[15], i_old_vel_y};
            r_l1  <= i_last_in;
            r_sqx <= 34'(w_sqx);
            r_sqy <= 34'(w_sqy);
            r_l2  <= r_l1;
            r_sq  <= r_sqx + r_sqy;
            r_l3  <= r_l2;
            r_pl  <= alhc_pkg::PL_W'(w_root) * alhc_pkg::PL_W'(r_inv[15:0]);
            r_ph  <= alhc_pkg::PL_W'(w_root) * alhc_pkg::PL_W'(r_inv[31:16]);
            r_lm1 <= w_sl;
            r_x   <= alhc_pkg::X_W'(r_pl) + alhc_pkg::X_W'({r_ph, 16'b0})
                     + (alhc_pkg::X_W'(1) << 32);
            r_lm2 <= r_lm1;
            r_x3  <= r_x;
            r_e3  <= n_e;
            r_lm3 <= r_lm2;
            r_m   <= w_sh[31:0];
            r_e4  <= r_e3;
            r_lm4 <= r_lm3;
            r_lo  <= alhc_pkg::LOG_ROM[alhc_pkg::ROM_AW'(w_idx)];
            r_hi  <= alhc_pkg::LOG_ROM[alhc_pkg::ROM_AW'(w_idx) + alhc_pkg::ROM_AW'(1)];
            r_r   <= r_m[31-alhc_pkg::LOG_B -: 16];
            r_e5  <= r_e4;
            r_lm5 <= r_lm4;
            r_prod <= 33'(w_diff) * 33'(r_r);
            r_lo6 <= r_lo;
            r_e6  <= r_e5;
            r_lm6 <= r_lm5;
            r_g   <= alhc_pkg::G_W'({r_e6, 16'b0}) + alhc_pkg::G_W'(r_lo6)
                     + alhc_pkg::G_W'(r_prod[32:16]);
            r_lm7 <= r_lm6;
            r_p   <= alhc_pkg::P_W'(r_g) * alhc_pkg::P_W'(alhc_pkg::LN2_Q16);
            r_lm8 <= r_lm7;
            r_d   <= alhc_pkg::D_W'(r_p[alhc_pkg::P_W-1:16])
                     * alhc_pkg::D_W'(alhc_pkg::RECIP10);
            r_lm9 <= r_lm8;
            r_f   <= (w_fs > 20'(alhc_pkg::ONE_Q16)) ? alhc_pkg::ONE_Q16 : w_fs[16:0];
            r_lm10 <= r_lm9;
            r_red    <= n_ch[0];
            r_green  <= n_ch[1];
            r_blue   <= n_ch[2];
            r_lo_out <= r_lm10;
        end
    end

    assign o_valid    = r_ov;
    assign o_red      = r_red;
    assign o_green    = r_green;
    assign o_blue     = r_blue;
    assign o_last_out = r_lo_out;

endmodule

`default_nettype wire

[rtl/alhc_checker.sv]
// ----------------------------------------------------------------------------
// alhc_checker
// Port-level checks for the heat-map colorizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_log_heatmap_colorizer_core_macros.svh"

module alhc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        i_psel,
    input wire logic        i_penable,
    input wire logic        i_pwrite,
    input wire logic [2:0]  i_paddr,
    input wire logic [31:0] i_pwdata,
    input wire logic [31:0] o_prdata,
    input wire logic        o_pready
);

    logic w_wr0;
    logic w_other;

    assign w_wr0   = i_psel && i_penable && i_pwrite && !i_paddr[2];
    assign w_other = i_paddr[2];

    `ALHC_ASSERT_IMP(a_pready_high, i_clk, i_rst_n, 1'b1, o_pready)
    `ALHC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ALHC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_ready, o_valid && !i_ready)
    `ALHC_ASSERT_NXT(a_reg_readback, i_clk, i_rst_n, w_wr0, w_other || (o_prdata == $past(i_pwdata)))

endmodule

bind accel_log_heatmap_colorizer_core alhc_checker u_alhc_checker (.*);

`default_nettype wire
